// ----- hdl/spat_pkg.sv -----
package spat_pkg;

  localparam int unsigned SeqW  = 16;
  localparam int unsigned TimeW = 32;

  // operation codes
  localparam logic OpSend = 1'b0;
  localparam logic OpAck  = 1'b1;

  // ceil(2^35 / 10): (x * Recip10) >> 35 equals x / 10 for every 32-bit x
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic             operation;
    logic [SeqW-1:0]  seq_number;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic             confirmed;
    logic             evicted_lost;
    logic [TimeW-1:0] sample_rtt_ms;
    logic [TimeW-1:0] smoothed_rtt_ms;
    logic [TimeW-1:0] lost_total;
    logic [TimeW-1:0] confirmed_total;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [SeqW-1:0]  seq;
    logic [TimeW-1:0] send_time;
  } slot_entry_t;

endpackage

// ----- hdl/spat_index.sv -----
// Slot index = seq mod Depth, two registered steps:
// estimate the quotient by a reciprocal multiply, then subtract and correct once.
module spat_index #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic                       clk_i,
  input  logic [spat_pkg::SeqW-1:0]  seq_i,
  output logic [IdxW-1:0]            idx_o
);

  localparam logic [31:0] Recip  = 32'((64'd1 << 32) / Depth);
  localparam logic [15:0] DepthW = 16'(Depth);

  logic [47:0] prod;
  logic [15:0] quo_q;
  logic [15:0] quo_times_d;
  logic [15:0] rem;
  logic [15:0] rem_fix;
  logic [IdxW-1:0] idx_q;

  // floor estimate is exact or one low, so the remainder stays below 2*Depth
  assign prod        = {32'd0, seq_i} * {16'd0, Recip};
  assign quo_times_d = quo_q * DepthW;
  assign rem         = seq_i - quo_times_d;
  assign rem_fix     = (rem >= DepthW) ? (rem - DepthW) : rem;

  always_ff @(posedge clk_i) begin
    quo_q <= prod[47:32];
    idx_q <= rem_fix[IdxW-1:0];
  end

  assign idx_o = idx_q;

endmodule

// ----- hdl/spat_slot_mem.sv -----
// Slot table: one write port, one read port with registered read data.
module spat_slot_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  spat_pkg::slot_entry_t wdata_i,
  input  logic [IdxW-1:0]       raddr_i,
  output spat_pkg::slot_entry_t rdata_o
);

  spat_pkg::slot_entry_t mem_q [Depth];
  spat_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/spat_rtt_smooth.sv -----
// Smoothed RTT: est' = sample + trunc((est - sample) * 9 / 10), or sample when est is zero.
// Works on |est - sample|: 9*m/10 = 9*(m/10) + max((m%10) - 1, 0).
// start_i loads the operands; est_o is valid once the operand and quotient registers have loaded, and holds.
module spat_rtt_smooth (
  input  logic        clk_i,
  input  logic        start_i,
  input  logic [31:0] est_i,
  input  logic [31:0] sample_i,
  output logic [31:0] est_o
);

  logic        neg_q;
  logic        load_q;
  logic [31:0] mag_q;
  logic [31:0] smp_q;
  logic [63:0] prod;
  logic [28:0] quo_q;
  logic [31:0] quo_x10;
  logic [31:0] rem;
  logic [3:0]  frac;
  logic [32:0] step_w;
  logic [31:0] step;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= (est_i < sample_i);
      mag_q  <= (est_i < sample_i) ? (sample_i - est_i) : (est_i - sample_i);
      smp_q  <= sample_i;
      load_q <= (est_i == 32'd0);
    end
    quo_q <= prod[63:35];
  end

  assign prod    = {32'd0, mag_q} * {32'd0, spat_pkg::Recip10};
  assign quo_x10 = {quo_q, 3'b000} + {2'b00, quo_q, 1'b0};
  assign rem     = mag_q - quo_x10;
  assign frac    = (rem[3:0] == 4'd0) ? 4'd0 : (rem[3:0] - 4'd1);
  assign step_w  = {1'b0, quo_q, 3'b000} + {4'b0000, quo_q} + {29'd0, frac};
  assign step    = step_w[31:0];

  always_comb begin
    if (load_q) begin
      est_o = smp_q;
    end else if (neg_q) begin
      est_o = smp_q - step;
    end else begin
      est_o = smp_q + step;
    end
  end

endmodule

// ----- hdl/sent_packet_ack_tracker.sv -----
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | spat_pkg::in_item_t   in_data_i
// out     | output    | out_valid_o / out_stall_i| spat_pkg::out_item_t  out_data_o
//
// A send or an unmatched ack passes through index multiply, index correction, slot read
// and evaluate/write back before the next acceptance; a matched ack also passes through
// the divide by 10 and the finish step before it.
// After reset a clearing pass sweeps every slot of the memory under in_stall_o.
// A result waits in the output register under out_stall_i while the next transaction
// is accepted; the block holds at evaluation or finish while that register is still full.
module sent_packet_ack_tracker #(
  parameter int unsigned TRACKER_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spat_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spat_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = $clog2(TRACKER_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TRACKER_DEPTH - 1);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StMod   = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StEval  = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [IdxW-1:0]       clr_q, clr_d;
  logic [31:0]           lost_q, lost_d;
  logic [31:0]           conf_q, conf_d;
  logic [31:0]           est_q, est_d;
  logic [31:0]           sample_q, sample_d;
  logic                  out_valid_q, out_valid_d;
  spat_pkg::out_item_t   out_q, out_d;
  spat_pkg::in_item_t    item_q;

  logic [IdxW-1:0]       idx;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  spat_pkg::slot_entry_t mem_wdata;
  spat_pkg::slot_entry_t rd;
  logic                  smooth_start;
  logic [31:0]           smooth_est;
  logic [31:0]           hit_sample;
  logic                  hit;
  logic                  out_free;

  spat_index #(
    .Depth (TRACKER_DEPTH),
    .IdxW  (IdxW)
  ) u_index (
    .clk_i (clk_i),
    .seq_i (item_q.seq_number),
    .idx_o (idx)
  );

  spat_slot_mem #(
    .Depth (TRACKER_DEPTH),
    .IdxW  (IdxW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx),
    .rdata_o (rd)
  );

  spat_rtt_smooth u_smooth (
    .clk_i    (clk_i),
    .start_i  (smooth_start),
    .est_i    (est_q),
    .sample_i (hit_sample),
    .est_o    (smooth_est)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hit_sample = item_q.now_ms - rd.send_time;
  assign hit        = rd.valid && (rd.seq == item_q.seq_number);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Items are serialized: a slot write lands before the next item's read is issued,
  // so no forwarding path is needed.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    lost_d       = lost_q;
    conf_d       = conf_q;
    est_d        = est_q;
    sample_d     = sample_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = rd;
    smooth_start = 1'b0;

    unique case (state_q)
      StClear: begin
        mem_we              = 1'b1;
        mem_waddr           = clr_q;
        mem_wdata.valid     = 1'b0;
        mem_wdata.seq       = '1;
        mem_wdata.send_time = '0;
        if (clr_q == LastIdx) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMul;
        end
      end
      StMul:  state_d = StMod;
      StMod:  state_d = StRead;
      StRead: state_d = StEval;
      StEval: begin
        if (item_q.operation == spat_pkg::OpAck && hit) begin
          // retire the slot now, finish the estimate after the divide
          mem_we          = 1'b1;
          mem_wdata.valid = 1'b0;
          conf_d          = conf_q + 32'd1;
          sample_d        = hit_sample;
          smooth_start    = 1'b1;
          state_d         = StDiv;
        end else if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.confirmed       = 1'b0;
          out_d.evicted_lost    = 1'b0;
          out_d.sample_rtt_ms   = '0;
          out_d.smoothed_rtt_ms = est_q;
          out_d.lost_total      = lost_q;
          out_d.confirmed_total = conf_q;
          if (item_q.operation == spat_pkg::OpSend) begin
            mem_we              = 1'b1;
            mem_wdata.valid     = 1'b1;
            mem_wdata.seq       = item_q.seq_number;
            mem_wdata.send_time = item_q.now_ms;
            lost_d              = lost_q + {31'd0, rd.valid};
            out_d.evicted_lost  = rd.valid;
            out_d.lost_total    = lost_q + {31'd0, rd.valid};
          end
          state_d = StIdle;
        end
      end
      StDiv: state_d = StFin;
      StFin: begin
        if (out_free) begin
          est_d                 = smooth_est;
          out_valid_d           = 1'b1;
          out_d.confirmed       = 1'b1;
          out_d.evicted_lost    = 1'b0;
          out_d.sample_rtt_ms   = sample_q;
          out_d.smoothed_rtt_ms = smooth_est;
          out_d.lost_total      = lost_q;
          out_d.confirmed_total = conf_q;
          state_d               = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      lost_q      <= '0;
      conf_q      <= '0;
      est_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lost_q      <= lost_d;
      conf_q      <= conf_d;
      est_q       <= est_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
    sample_q <= sample_d;
    out_q    <= out_d;
  end

  // a new result is only loaded from evaluation or from the smoothing finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StEval || $past(state_q) == StFin))
    else $error("result loaded outside evaluation");

  // the loss counter moves only when a send is evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lost_q != $past(lost_q)) |-> ($past(state_q) == StEval))
    else $error("loss counter changed outside evaluation");

  // a matched ack always reaches the finish step right after the divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smooth_start |-> ##2 (state_q == StFin))
    else $error("smoothing result not collected");

  // a result never reports both a confirmation and an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.confirmed && out_q.evicted_lost))
    else $error("confirmed and evicted in one result");

endmodule

// ----- tb/sv/tb_sent_packet_ack_tracker.sv -----
module tb_sent_packet_ack_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount = 64;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  spat_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  spat_pkg::out_item_t out_data_o;

  sent_packet_ack_tracker #(
    .TRACKER_DEPTH(SlotCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow of the tracker state
  logic [spat_pkg::SeqW-1:0]  slot_seq     [SlotCount];
  logic                       slot_live    [SlotCount];
  logic [spat_pkg::TimeW-1:0] slot_sent_at [SlotCount];
  logic [spat_pkg::TimeW-1:0] lost_count;
  logic [spat_pkg::TimeW-1:0] confirm_count;
  logic [spat_pkg::TimeW-1:0] rtt_avg;

  spat_pkg::out_item_t        expected_reports[$];
  int unsigned                error_count = 0;
  int unsigned                send_idle_pct = 0;
  int unsigned                recv_idle_pct = 0;
  logic [spat_pkg::TimeW-1:0] clock_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [spat_pkg::TimeW-1:0] blend_rtt(
      logic [spat_pkg::TimeW-1:0] prev, logic [spat_pkg::TimeW-1:0] sample);
    longint diff;
    longint step;
    longint next_est;
    if (prev == '0) return sample;
    diff = $signed({32'b0, prev}) - $signed({32'b0, sample});
    // signed division truncates toward zero
    step = (diff * 9) / 10;
    next_est = $signed({32'b0, sample}) + step;
    return next_est[spat_pkg::TimeW-1:0];
  endfunction

  function automatic spat_pkg::out_item_t apply_packet_event(spat_pkg::in_item_t item);
    spat_pkg::out_item_t res;
    int unsigned         slot;
    res = '0;
    slot = item.seq_number % SlotCount;
    if (item.operation == spat_pkg::OpSend) begin
      if (slot_live[slot]) begin
        res.evicted_lost = 1'b1;
        lost_count = lost_count + 1;
      end
      slot_seq[slot] = item.seq_number;
      slot_sent_at[slot] = item.now_ms;
      slot_live[slot] = 1'b1;
    end else if (slot_live[slot] && slot_seq[slot] == item.seq_number) begin
      res.confirmed = 1'b1;
      res.sample_rtt_ms = item.now_ms - slot_sent_at[slot];
      rtt_avg = blend_rtt(rtt_avg, res.sample_rtt_ms);
      confirm_count = confirm_count + 1;
      slot_live[slot] = 1'b0;
    end
    res.smoothed_rtt_ms = rtt_avg;
    res.lost_total = lost_count;
    res.confirmed_total = confirm_count;
    return res;
  endfunction

  task automatic send_packet_event(logic op, logic [spat_pkg::SeqW-1:0] seq,
                                   logic [spat_pkg::TimeW-1:0] now);
    spat_pkg::in_item_t item;
    item.operation = op;
    item.seq_number = seq;
    item.now_ms = now;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reports.insert(expected_reports.size(), apply_packet_event(item));
  endtask

  task automatic check_report(spat_pkg::out_item_t got);
    spat_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      report_error($sformatf("result with none pending: %p", got));
      return;
    end
    want = expected_reports.pop_front();
    if (got.confirmed !== want.confirmed)
      report_error($sformatf("confirmed got %0b want %0b", got.confirmed, want.confirmed));
    if (got.evicted_lost !== want.evicted_lost)
      report_error($sformatf("evicted_lost got %0b want %0b",
                             got.evicted_lost, want.evicted_lost));
    if (got.sample_rtt_ms !== want.sample_rtt_ms)
      report_error($sformatf("sample_rtt_ms got %0d want %0d",
                             got.sample_rtt_ms, want.sample_rtt_ms));
    if (got.smoothed_rtt_ms !== want.smoothed_rtt_ms)
      report_error($sformatf("smoothed_rtt_ms got %0d want %0d",
                             got.smoothed_rtt_ms, want.smoothed_rtt_ms));
    if (got.lost_total !== want.lost_total)
      report_error($sformatf("lost_total got %0d want %0d", got.lost_total, want.lost_total));
    if (got.confirmed_total !== want.confirmed_total)
      report_error($sformatf("confirmed_total got %0d want %0d",
                             got.confirmed_total, want.confirmed_total));
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_report(out_data_o);
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // runs right after reset, while the estimate is still zero
  task automatic test_rtt_restart();
    send_packet_event(spat_pkg::OpSend, 16'd5, 32'd100);
    send_packet_event(spat_pkg::OpAck, 16'd5, 32'd101);
    // a zero sample pulls an estimate of one back to zero
    send_packet_event(spat_pkg::OpSend, 16'd6, 32'd200);
    send_packet_event(spat_pkg::OpAck, 16'd6, 32'd200);
    send_packet_event(spat_pkg::OpSend, 16'd7, 32'd300);
    send_packet_event(spat_pkg::OpAck, 16'd7, 32'd350);
    send_packet_event(spat_pkg::OpAck, 16'd8, 32'd360);
  endtask

  task automatic test_field_extremes();
    send_packet_event(spat_pkg::OpSend, 16'h0000, 32'h0000_0000);
    send_packet_event(spat_pkg::OpSend, 16'hFFFF, 32'hFFFF_FFFF);
    send_packet_event(spat_pkg::OpAck, 16'hFFFF, 32'h0000_0004);
    send_packet_event(spat_pkg::OpAck, 16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_clock_backwards();
    send_packet_event(spat_pkg::OpSend, 16'd100, 32'd5000);
    send_packet_event(spat_pkg::OpAck, 16'd100, 32'd1000);
  endtask

  task automatic test_unmatched_acks();
    send_packet_event(spat_pkg::OpSend, 16'h0041, 32'd10);
    send_packet_event(spat_pkg::OpAck, 16'h0001, 32'd20);
    send_packet_event(spat_pkg::OpAck, 16'h0041, 32'd25);
    send_packet_event(spat_pkg::OpAck, 16'h0041, 32'd30);
  endtask

  task automatic test_eviction();
    send_packet_event(spat_pkg::OpSend, 16'h0002, 32'd30);
    send_packet_event(spat_pkg::OpSend, 16'h0042, 32'd40);
    send_packet_event(spat_pkg::OpAck, 16'h0002, 32'd45);
    send_packet_event(spat_pkg::OpAck, 16'h0042, 32'd47);
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                     int unsigned recv_pct);
    logic [spat_pkg::SeqW-1:0] in_flight[$];
    logic [spat_pkg::SeqW-1:0] seq;
    int unsigned               pick;
    int unsigned               roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      // mostly advance time, now and then jump anywhere
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 40);
      if (roll < 45 || in_flight.size() == 0) begin
        seq = 16'($urandom_range(0, 65535));
        in_flight.insert(in_flight.size(), seq);
        if (in_flight.size() > 48) void'(in_flight.pop_front());
        send_packet_event(spat_pkg::OpSend, seq, clock_ms);
      end else if (roll < 85) begin
        pick = $urandom_range(0, in_flight.size() - 1);
        seq = in_flight[pick];
        in_flight.delete(pick);
        send_packet_event(spat_pkg::OpAck, seq, clock_ms);
      end else if (roll < 93) begin
        // same slot, different sequence
        seq = in_flight[$urandom_range(0, in_flight.size() - 1)];
        seq = seq ^ (16'h0001 << $urandom_range(6, 15));
        send_packet_event(spat_pkg::OpAck, seq, clock_ms);
      end else begin
        send_packet_event(spat_pkg::OpAck, 16'($urandom_range(0, 65535)), clock_ms);
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < SlotCount; i++) begin
      slot_seq[i] = '1;
      slot_live[i] = 1'b0;
      slot_sent_at[i] = '0;
    end
    lost_count = '0;
    confirm_count = '0;
    rtt_avg = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 83;
    test_rtt_restart();
    test_field_extremes();
    test_clock_backwards();
    test_unmatched_acks();
    test_eviction();

    test_random_traffic(700, 38, 83);
    test_random_traffic(700, 83, 38);
    test_random_traffic(600, 0, 0);
    in_valid_i <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
